// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the leak meter RTL.
// Each macro expects clk_i and rst_ni to be visible in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define DTG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition is followed by a consequence in the next cycle.
`define DTG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/dtglm_pkg.sv =====
// Shared types and constants of the dual-tone leak meter.
// Used by the controller, the datapath and the top level; no dependencies.
package dtglm_pkg;

  // Configuration port geometry and register indices
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEFF_50   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEFF_60   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HPF_POLE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_K     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET     = 3'd7;

  // Result field widths
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned LEAK_W   = 24;

  // Square root steps, one result bit each
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned SQ_CNT_W   = 5;

  // Datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_HPF, OP_MH, OP_ML, OP_MS, OP_RES,
    OP_PAA, OP_PBB, OP_PMB, OP_RA, OP_RB, OP_RC, OP_SQ,
    OP_G1, OP_G2, OP_G3, OP_G4, OP_AV1, OP_AV2
  } op_e;

  typedef struct packed {
    op_e  op;
    logic sel;   // 0: 50 Hz resonator, 1: 60 Hz resonator
  } cmd_t;

  typedef struct packed {
    logic wend;      // window count has reached its length
    logic out_full;  // result register holds an untaken result
  } stat_t;

endpackage

// ===== hw/rtl/dtglm_datapath.sv =====
// Datapath of the leak meter: config registers, high-pass filter, resonators,
// power, frequency choice, square root, scaling and averaging. Uses dtglm_pkg.
`include "assert_macros.svh"

module dtglm_datapath #(
  parameter int unsigned SAMPLE_WIDTH    = 16,
  parameter int unsigned SELECT_RATIO_Q8 = 333
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  dtglm_pkg::cmd_t                    cmd_i,
  output dtglm_pkg::stat_t                   stat_o,
  input  logic [dtglm_pkg::SAMPLE_W-1:0]     sample_i,
  input  logic                               cfg_we_i,
  input  logic [dtglm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [dtglm_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [dtglm_pkg::LEAK_W-1:0]       leak_ma_o,
  output logic                               is_60hz_o
);

  localparam int unsigned SHIFT_X = dtglm_pkg::SAMPLE_W - SAMPLE_WIDTH;
  localparam logic [10:0] RATIO   = 11'(SELECT_RATIO_Q8);
  localparam logic [23:0] MAX24   = 24'hFFFFFF;

  // Configuration registers
  logic        [15:0] win_len_q;
  logic signed [31:0] c50_q, c60_q;
  logic        [14:0] pole_q;
  logic        [31:0] gain_q;
  logic        [16:0] smooth_q;
  logic        [23:0] dead_q, off_q;

  // Filter and resonator state
  logic signed [15:0] x_q, last_in_q;
  logic signed [39:0] last_out_q, y_q;
  logic signed [47:0] r_a_q [2];
  logic signed [47:0] r_b_q [2];
  logic        [15:0] count_q;

  // Intermediate results
  logic signed [63:0] ph_q;
  logic signed [48:0] pl_q;
  logic signed [49:0] m_q;
  logic signed [63:0] acc_q;
  logic        [62:0] p_q [2];
  logic        [74:0] ry_q;
  logic               gt60_q, chose_q;
  logic        [63:0] rad_q;
  logic        [34:0] rem_q;
  logic        [31:0] root_q;
  logic               big_q;
  logic        [71:0] gp_q;
  logic        [23:0] raw_q, xm_q, avg_q;
  logic signed [42:0] avp_q;
  logic               out_valid_q, is60_q;
  logic        [23:0] leak_q;

  function automatic logic signed [31:0] clamp_i30(input logic signed [31:0] v);
    if (v > 32'sh4000_0000)       return 32'sh4000_0000;
    else if (v < -32'sh4000_0000) return -32'sh4000_0000;
    else                          return v;
  endfunction

  function automatic logic signed [32:0] clamp_m31(input logic signed [33:0] v);
    if (v > 34'sh0_8000_0000)       return 33'sh0_8000_0000;
    else if (v < -34'sh0_8000_0000) return 33'sh1_8000_0000;
    else                            return v[32:0];
  endfunction

  // Select the resonator under work
  logic signed [31:0] c_sel;
  logic signed [47:0] a_sel, b_sel;
  assign c_sel = cmd_i.sel ? c60_q : c50_q;
  assign a_sel = r_a_q[cmd_i.sel];
  assign b_sel = r_b_q[cmd_i.sel];

  // Sample sign extension from the configured width
  logic signed [15:0] x_ext;
  assign x_ext = $signed(sample_i << SHIFT_X) >>> SHIFT_X;

  // High-pass filter
  logic signed [55:0] hprod;
  logic signed [16:0] hdiff;
  logic signed [41:0] ysum;
  logic signed [39:0] y_sat;
  assign hprod = $signed({1'b0, pole_q}) * last_out_q;
  assign hdiff = {x_q[15], x_q} - {last_in_q[15], last_in_q};
  assign ysum  = $signed({{9{hdiff[16]}}, hdiff, 16'b0}) + $signed({hprod[55], hprod[55:15]});
  always_comb begin
    if (ysum[41:39] == 3'b000 || ysum[41:39] == 3'b111) y_sat = ysum[39:0];
    else if (ysum[41])                                 y_sat = {1'b1, 39'b0};
    else                                               y_sat = {1'b0, {39{1'b1}}};
  end

  // Coefficient times state, floor of the product over 2^30
  logic signed [63:0] ph_d;
  logic signed [48:0] pl_d;
  logic signed [79:0] msum;
  assign ph_d = c_sel * $signed(a_sel[47:16]);
  assign pl_d = c_sel * $signed({1'b0, a_sel[15:0]});
  assign msum = $signed({ph_q, 16'b0}) + 80'(pl_q);

  // Resonator update with saturation to 48 bits
  logic signed [51:0] s_sum;
  logic signed [47:0] s_sat;
  assign s_sum = 52'(y_q) + 52'(m_q) - 52'(b_sel);
  always_comb begin
    if (s_sum[51:47] == 5'b00000 || s_sum[51:47] == 5'b11111) s_sat = s_sum[47:0];
    else if (s_sum[51])                                        s_sat = {1'b1, 47'b0};
    else                                                       s_sat = {1'b0, {47{1'b1}}};
  end

  // Power terms
  logic signed [31:0] ai, bi;
  logic signed [32:0] mi;
  logic signed [64:0] mb, pv;
  assign ai = clamp_i30($signed(a_sel[47:16]));
  assign bi = clamp_i30($signed(b_sel[47:16]));
  assign mi = clamp_m31($signed(m_q[49:16]));
  assign mb = mi * bi;
  assign pv = 65'(acc_q) - mb;

  // Frequency choice
  logic        gt50, chose_n;
  logic [62:0] p_pick;
  assign gt50    = {4'b0, p_q[0], 8'b0} > ry_q;
  assign chose_n = gt60_q ? 1'b1 : (gt50 ? 1'b0 : chose_q);
  assign p_pick  = chose_n ? p_q[1] : p_q[0];

  // Square root step
  logic [36:0] rem_n, trial;
  assign rem_n = {rem_q, rad_q[63:62]};
  assign trial = {3'b0, root_q, 2'b01};

  // Scaling and averaging
  logic [39:0] root40;
  logic [75:0] t10;
  logic [16:0] alpha;
  logic signed [24:0] adiff;
  logic signed [27:0] nv;
  logic [23:0] avg_n;
  assign root40 = big_q ? {root_q, 8'b0} : {8'b0, root_q};
  assign t10    = {1'b0, gp_q, 3'b0} + {3'b0, gp_q, 1'b0};
  assign alpha  = (smooth_q > 17'h10000) ? 17'h10000 : smooth_q;
  assign adiff  = $signed({1'b0, xm_q}) - $signed({1'b0, avg_q});
  assign nv     = $signed({4'b0, avg_q}) + 28'($signed(avp_q[42:16]));
  always_comb begin
    if (nv < 0)                    avg_n = '0;
    else if (nv > 28'sh0FF_FFFF)   avg_n = MAX24;
    else                           avg_n = nv[23:0];
    if (avg_n < dead_q) avg_n = '0;
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q <= 16'd100;
      c50_q     <= 32'sd2042378283;
      c60_q     <= 32'sd1996679829;
      pole_q    <= 15'd32604;
      gain_q    <= 32'd65536;
      smooth_q  <= 17'd6554;
      dead_q    <= '0;
      off_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dtglm_pkg::CFG_WINDOW_LEN: win_len_q <= cfg_data_i[15:0];
        dtglm_pkg::CFG_COEFF_50:   c50_q     <= $signed(cfg_data_i);
        dtglm_pkg::CFG_COEFF_60:   c60_q     <= $signed(cfg_data_i);
        dtglm_pkg::CFG_HPF_POLE:   pole_q    <= cfg_data_i[14:0];
        dtglm_pkg::CFG_GAIN_K:     gain_q    <= cfg_data_i;
        dtglm_pkg::CFG_SMOOTHING:  smooth_q  <= cfg_data_i[16:0];
        dtglm_pkg::CFG_DEADBAND:   dead_q    <= cfg_data_i[23:0];
        dtglm_pkg::CFG_OFFSET:     off_q     <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  // Control state: filter memory, resonators, window count, averaging, result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_in_q   <= 16'sd2048;
      last_out_q  <= 40'sd134217728;
      r_a_q[0]    <= '0;
      r_a_q[1]    <= '0;
      r_b_q[0]    <= '0;
      r_b_q[1]    <= '0;
      count_q     <= '0;
      chose_q     <= 1'b0;
      avg_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // Drop the result once transferred, unless a new one lands now
      if (out_valid_q && out_ready_i && cmd_i.op != dtglm_pkg::OP_AV2) out_valid_q <= 1'b0;
      case (cmd_i.op)
        dtglm_pkg::OP_LOAD: count_q <= count_q + 16'd1;
        dtglm_pkg::OP_HPF: begin
          last_in_q  <= x_q;
          last_out_q <= y_sat;
        end
        dtglm_pkg::OP_RES: begin
          r_b_q[cmd_i.sel] <= a_sel;
          r_a_q[cmd_i.sel] <= s_sat;
        end
        dtglm_pkg::OP_RC: chose_q <= chose_n;
        dtglm_pkg::OP_AV2: begin
          avg_q       <= avg_n;
          out_valid_q <= 1'b1;
          r_a_q[0]    <= '0;
          r_a_q[1]    <= '0;
          r_b_q[0]    <= '0;
          r_b_q[1]    <= '0;
          count_q     <= '0;
        end
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      dtglm_pkg::OP_LOAD: x_q  <= x_ext;
      dtglm_pkg::OP_HPF:  y_q  <= y_sat;
      dtglm_pkg::OP_MH:   ph_q <= ph_d;
      dtglm_pkg::OP_ML:   pl_q <= pl_d;
      dtglm_pkg::OP_MS:   m_q  <= msum[79:30];
      dtglm_pkg::OP_PAA:  acc_q <= ai * ai;
      dtglm_pkg::OP_PBB:  acc_q <= acc_q + bi * bi;
      dtglm_pkg::OP_PMB:  p_q[cmd_i.sel] <= pv[64] ? 63'd0 : pv[62:0];
      dtglm_pkg::OP_RA:   ry_q <= 75'(p_q[0]) * 75'(RATIO);
      dtglm_pkg::OP_RB: begin
        gt60_q <= {4'b0, p_q[1], 8'b0} > ry_q;
        ry_q   <= 75'(p_q[1]) * 75'(RATIO);
      end
      dtglm_pkg::OP_RC: begin
        big_q  <= |p_pick[62:46];
        rad_q  <= (|p_pick[62:46]) ? {1'b0, p_pick} : {p_pick[47:0], 16'b0};
        rem_q  <= '0;
        root_q <= '0;
      end
      dtglm_pkg::OP_SQ: begin
        rad_q <= {rad_q[61:0], 2'b00};
        if (rem_n >= trial) begin
          rem_q  <= 35'(rem_n - trial);
          root_q <= {root_q[30:0], 1'b1};
        end else begin
          rem_q  <= rem_n[34:0];
          root_q <= {root_q[30:0], 1'b0};
        end
      end
      dtglm_pkg::OP_G1:  gp_q  <= {8'b0, 64'(gain_q) * 64'(root40[31:0])};
      dtglm_pkg::OP_G2:  gp_q  <= gp_q + {40'(gain_q) * 40'(root40[39:32]), 32'b0};
      dtglm_pkg::OP_G3:  raw_q <= (|t10[75:40]) ? MAX24 : t10[39:16];
      dtglm_pkg::OP_G4:  xm_q  <= (raw_q > off_q) ? raw_q - off_q : 24'd0;
      dtglm_pkg::OP_AV1: avp_q <= $signed({1'b0, alpha}) * adiff;
      dtglm_pkg::OP_AV2: begin
        leak_q <= avg_n;
        is60_q <= chose_q;
      end
      default: ;
    endcase
  end

  assign stat_o.wend     = count_q >= win_len_q;
  assign stat_o.out_full = out_valid_q && !out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign leak_ma_o       = leak_q;
  assign is_60hz_o       = is60_q;

  `DTG_ASSERT(a_no_overwrite, cmd_i.op != dtglm_pkg::OP_AV2 || !out_valid_q || out_ready_i, "result overwritten before transfer")
  `DTG_ASSERT_NEXT(a_window_clear, cmd_i.op == dtglm_pkg::OP_AV2, count_q == 16'd0 && out_valid_q, "window not restarted after result")

endmodule

// ===== hw/rtl/dtglm_ctrl.sv =====
// Sequencing controller of the leak meter: walks the datapath through one sample
// and, at window end, through power, choice, root and averaging. Uses dtglm_pkg.
`include "assert_macros.svh"

module dtglm_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  dtglm_pkg::stat_t       stat_i,
  output dtglm_pkg::cmd_t        cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_HPF, ST_MH, ST_ML, ST_MS, ST_RES, ST_PAA, ST_PBB, ST_PMB,
    ST_RA, ST_RB, ST_RC, ST_SQ, ST_G1, ST_G2, ST_G3, ST_G4, ST_AV1, ST_AV2
  } st_e;

  st_e                             st_q;
  logic                            sel_q;
  logic                            pwr_q;
  logic [dtglm_pkg::SQ_CNT_W-1:0]  sq_cnt_q;

  localparam logic [dtglm_pkg::SQ_CNT_W-1:0] SQ_LAST =
    dtglm_pkg::SQ_CNT_W'(dtglm_pkg::SQRT_STEPS - 1);

  // Decode the datapath operation of the current state
  always_comb begin
    cmd_o.sel = sel_q;
    case (st_q)
      ST_IDLE: cmd_o.op = in_valid_i ? dtglm_pkg::OP_LOAD : dtglm_pkg::OP_NONE;
      ST_HPF:  cmd_o.op = dtglm_pkg::OP_HPF;
      ST_MH:   cmd_o.op = dtglm_pkg::OP_MH;
      ST_ML:   cmd_o.op = dtglm_pkg::OP_ML;
      ST_MS:   cmd_o.op = dtglm_pkg::OP_MS;
      ST_RES:  cmd_o.op = dtglm_pkg::OP_RES;
      ST_PAA:  cmd_o.op = dtglm_pkg::OP_PAA;
      ST_PBB:  cmd_o.op = dtglm_pkg::OP_PBB;
      ST_PMB:  cmd_o.op = dtglm_pkg::OP_PMB;
      ST_RA:   cmd_o.op = dtglm_pkg::OP_RA;
      ST_RB:   cmd_o.op = dtglm_pkg::OP_RB;
      ST_RC:   cmd_o.op = dtglm_pkg::OP_RC;
      ST_SQ:   cmd_o.op = dtglm_pkg::OP_SQ;
      ST_G1:   cmd_o.op = dtglm_pkg::OP_G1;
      ST_G2:   cmd_o.op = dtglm_pkg::OP_G2;
      ST_G3:   cmd_o.op = dtglm_pkg::OP_G3;
      ST_G4:   cmd_o.op = dtglm_pkg::OP_G4;
      ST_AV1:  cmd_o.op = dtglm_pkg::OP_AV1;
      ST_AV2:  cmd_o.op = stat_i.out_full ? dtglm_pkg::OP_NONE : dtglm_pkg::OP_AV2;
      default: cmd_o.op = dtglm_pkg::OP_NONE;
    endcase
  end

  assign in_ready_o = (st_q == ST_IDLE);

  // Advance the sequence
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      sel_q    <= 1'b0;
      pwr_q    <= 1'b0;
      sq_cnt_q <= '0;
    end else begin
      case (st_q)
        ST_IDLE: if (in_valid_i) st_q <= ST_HPF;
        ST_HPF: begin
          st_q  <= ST_MH;
          sel_q <= 1'b0;
          pwr_q <= 1'b0;
        end
        ST_MH: st_q <= ST_ML;
        ST_ML: st_q <= ST_MS;
        ST_MS: st_q <= pwr_q ? ST_PAA : ST_RES;
        ST_RES: begin
          if (!sel_q) begin
            sel_q <= 1'b1;
            st_q  <= ST_MH;
          end else if (stat_i.wend) begin
            sel_q <= 1'b0;
            pwr_q <= 1'b1;
            st_q  <= ST_MH;
          end else begin
            st_q <= ST_IDLE;
          end
        end
        ST_PAA: st_q <= ST_PBB;
        ST_PBB: st_q <= ST_PMB;
        ST_PMB: begin
          if (!sel_q) begin
            sel_q <= 1'b1;
            st_q  <= ST_MH;
          end else begin
            st_q <= ST_RA;
          end
        end
        ST_RA: st_q <= ST_RB;
        ST_RB: st_q <= ST_RC;
        ST_RC: begin
          st_q     <= ST_SQ;
          sq_cnt_q <= '0;
        end
        ST_SQ: begin
          if (sq_cnt_q == SQ_LAST) st_q <= ST_G1;
          else                     sq_cnt_q <= sq_cnt_q + 1'b1;
        end
        ST_G1:  st_q <= ST_G2;
        ST_G2:  st_q <= ST_G3;
        ST_G3:  st_q <= ST_G4;
        ST_G4:  st_q <= ST_AV1;
        ST_AV1: st_q <= ST_AV2;
        ST_AV2: if (!stat_i.out_full) st_q <= ST_IDLE;
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  `DTG_ASSERT(a_ready_ops, !in_ready_o || cmd_o.op == dtglm_pkg::OP_LOAD || cmd_o.op == dtglm_pkg::OP_NONE, "work issued while ready")
  `DTG_ASSERT_NEXT(a_accept_hpf, in_valid_i && in_ready_o, st_q == ST_HPF, "accepted sample not filtered")
  `DTG_ASSERT_NEXT(a_root_start, st_q == ST_RC, st_q == ST_SQ && sq_cnt_q == '0, "root not started")

endmodule

// ===== hw/rtl/dual_tone_goertzel_leak_meter.sv =====
// Top level of the dual-tone 50/60 Hz leakage meter.
// Joins dtglm_ctrl and dtglm_datapath; uses dtglm_pkg.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+-------------------------------
//   input    | in_valid_i / in_ready_o   | sample_i
//   result   | out_valid_o / out_ready_i | leak_ma_o, is_60hz_o
//   config   | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
// A sample inside a window is loaded, filtered, then makes two resonator passes through
// one shared coefficient multiply path. A window-end sample adds power, choice, root,
// scaling, averaging and any result-register wait; the 32-step square root dominates.
// Reset is asynchronous, active low, and leaves the block ready with no clearing pass.
// A result waiting on out_ready_i holds the next window end only; samples still transfer.
module dual_tone_goertzel_leak_meter #(
  parameter int unsigned SELECT_RATIO_Q8 = 333,
  parameter int unsigned SAMPLE_WIDTH    = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [dtglm_pkg::SAMPLE_W-1:0]    sample_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [dtglm_pkg::LEAK_W-1:0]      leak_ma_o,
  output logic                              is_60hz_o,
  input  logic                              cfg_we_i,
  input  logic [dtglm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [dtglm_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  dtglm_pkg::cmd_t  cmd;
  dtglm_pkg::stat_t stat;

  // Sequencer
  dtglm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Arithmetic and state
  dtglm_datapath #(
    .SAMPLE_WIDTH    (SAMPLE_WIDTH),
    .SELECT_RATIO_Q8 (SELECT_RATIO_Q8)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .sample_i    (sample_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .leak_ma_o   (leak_ma_o),
    .is_60hz_o   (is_60hz_o)
  );

endmodule
